[rtl/prc_pkg.sv]
// Package: shared types, codes and helper functions for the rule classifier.
`default_nettype none

package prc_pkg;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_MATCH  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Protocol codes
    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ANY   = 8'd143;
    localparam logic [7:0] PROTO_OTHER = 8'd255;

    localparam logic [1:0] DIR_ANY = 2'd3;

    localparam logic [1:0] ACK_YES = 2'd2;
    localparam logic [1:0] ACK_ANY = 2'd3;

    localparam logic [9:0] PORT_WILD = 10'd0;
    localparam logic [9:0] PORT_HIGH = 10'd1023;

    localparam logic [5:0] PREFIX_MAX = 6'd32;

    // One input item as taken from the ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  direction;
        logic [31:0] src_ip;
        logic [5:0]  src_prefix_len;
        logic [31:0] dst_ip;
        logic [5:0]  dst_prefix_len;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack_code;
        logic [7:0]  verdict;
        logic [5:0]  rule_index;
    } t_item;

    // Packet fields used by the match logic
    typedef struct packed {
        logic [1:0]  direction;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack_code;
    } t_pkt;

    // Stored rule; ports of a valid rule fit in 10 bits
    typedef struct packed {
        logic [1:0]  direction;
        logic [31:0] src_ip;
        logic [31:0] src_mask;
        logic [31:0] dst_ip;
        logic [31:0] dst_mask;
        logic [7:0]  proto;
        logic [9:0]  sport;
        logic [9:0]  dport;
        logic [1:0]  ack_code;
        logic        action;
    } t_rule;

    // Top len bits set; len 0 gives 0, len 32 all ones (shift by 32 yields 0)
    function automatic logic [31:0] len_to_mask(input logic [5:0] len);
        len_to_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

`default_nettype wire

[rtl/packet_rule_classifier_unit.sv]
// Top level: packet rule classifier (rule table with clear, append and match items).
// Pipeline from input accept to result valid: input reg, table read, result reg.
// Throughput: one item per cycle; every stage moves whenever the next one has room.
// Reset (i_rst_n low, synchronous): empties the pipeline and sets the rule count to 0.
// Table contents are not cleared; entries at or above the count never affect a result.
`default_nettype none

module packet_rule_classifier_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input item channel
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_kind,
    input  wire  [1:0]  i_direction,
    input  wire  [31:0] i_src_ip,
    input  wire  [5:0]  i_src_prefix_len,
    input  wire  [31:0] i_dst_ip,
    input  wire  [5:0]  i_dst_prefix_len,
    input  wire  [7:0]  i_proto,
    input  wire  [15:0] i_src_port,
    input  wire  [15:0] i_dst_port,
    input  wire  [1:0]  i_ack_code,
    input  wire  [7:0]  i_verdict,
    input  wire  [5:0]  i_rule_index,
    // result item channel
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic        o_matched,
    output logic        o_rule_verdict,
    output logic [6:0]  o_count
);
    import prc_pkg::*;

    // Table address and rule count widths
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // ---------------------------------------------------------------
    // Pipeline flow control: each stage moves when the next has room.
    // ---------------------------------------------------------------
    logic w_en2;   // stage 1 -> stage 2
    logic w_en3;   // stage 2 -> result register
    logic w_accept;

    logic r1_valid;
    logic r2_valid;
    logic r3_valid;

    assign w_en3    = !r3_valid || i_ready;
    assign w_en2    = !r2_valid || w_en3;
    assign o_ready  = !r1_valid || w_en2;
    assign w_accept = i_valid && o_ready;

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    t_item r1_item;
    t_item w_in_item;

    always_comb begin
        w_in_item.kind           = i_kind;
        w_in_item.direction      = i_direction;
        w_in_item.src_ip         = i_src_ip;
        w_in_item.src_prefix_len = i_src_prefix_len;
        w_in_item.dst_ip         = i_dst_ip;
        w_in_item.dst_prefix_len = i_dst_prefix_len;
        w_in_item.proto          = i_proto;
        w_in_item.sport          = i_src_port;
        w_in_item.dport          = i_dst_port;
        w_in_item.ack_code       = i_ack_code;
        w_in_item.verdict        = i_verdict;
        w_in_item.rule_index     = i_rule_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (o_ready) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_item <= w_in_item;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 work: validate appends, write the table, update the
    // count, and launch the table read for match items. The item in
    // stage 1 is the only one that touches the count, so a match sees
    // every earlier append already written.
    // ---------------------------------------------------------------
    logic          w_rule_ok;
    t_rule         w_new_rule;
    logic          w_go1;        // stage 1 item moves on this cycle
    logic          w_full;
    logic          w_we;
    logic [1:0]    n_status;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_in_range;
    logic [AW-1:0] w_raddr;
    t_rule         w_rdata;

    prc_check u_check (
        .i_item    (r1_item),
        .o_rule_ok (w_rule_ok),
        .o_rule    (w_new_rule)
    );

    assign w_go1      = r1_valid && w_en2;
    assign w_full     = (r_count == CW'(TABLE_DEPTH));
    assign w_in_range = ((CW + 6)'(r1_item.rule_index) < (CW + 6)'(r_count));
    assign w_raddr    = AW'(r1_item.rule_index);

    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        w_we     = 1'b0;
        case (r1_item.kind)
            KIND_CLEAR: begin
                n_count = '0;
            end
            KIND_APPEND: begin
                // full takes priority over a malformed rule
                if (w_full) begin
                    n_status = ST_FULL;
                end else if (!w_rule_ok) begin
                    n_status = ST_INVALID;
                end else begin
                    w_we    = w_go1;
                    n_count = r_count + CW'(1);
                end
            end
            default: begin
                // match and unused kind leave the table alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_go1) begin
            r_count <= n_count;
        end
    end

    prc_rule_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_rule_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_count)),
        .i_wdata (w_new_rule),
        .i_re    (w_go1),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------
    // Stage 2: item side-band alongside the registered table read
    // ---------------------------------------------------------------
    t_pkt          w_pkt;
    t_pkt          r2_pkt;
    logic          r2_is_match;
    logic [1:0]    r2_status;
    logic [CW-1:0] r2_count;

    always_comb begin
        w_pkt.direction = r1_item.direction;
        w_pkt.src_ip    = r1_item.src_ip;
        w_pkt.dst_ip    = r1_item.dst_ip;
        w_pkt.proto     = r1_item.proto;
        w_pkt.sport     = r1_item.sport;
        w_pkt.dport     = r1_item.dport;
        w_pkt.ack_code  = r1_item.ack_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go1) begin
            r2_pkt      <= w_pkt;
            r2_is_match <= (r1_item.kind == KIND_MATCH) && w_in_range;
            r2_status   <= n_status;
            r2_count    <= n_count;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2 work: compare against the fetched rule, then the result
    // register. Only in-range match items report a hit or a verdict.
    // ---------------------------------------------------------------
    logic          w_hit;
    logic          w_go2;
    logic [1:0]    r3_status;
    logic          r3_matched;
    logic          r3_verdict;
    logic [CW-1:0] r3_count;

    prc_match u_match (
        .i_pkt  (r2_pkt),
        .i_rule (w_rdata),
        .o_hit  (w_hit)
    );

    assign w_go2 = r2_valid && w_en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go2) begin
            r3_status  <= r2_status;
            r3_matched <= r2_is_match && w_hit;
            r3_verdict <= r2_is_match && w_rdata.action;
            r3_count   <= r2_count;
        end
    end

    assign o_valid        = r3_valid;
    assign o_status       = r3_status;
    assign o_matched      = r3_matched;
    assign o_rule_verdict = r3_verdict;
    assign o_count        = 7'(r3_count);

`ifndef SYNTHESIS
    // count never runs past the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("rule count exceeds table depth");

    // a table write raises the count by exactly one
    a_write_bumps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_count == $past(r_count) + CW'(1)))
        else $error("table write without count increment");

    // a clear item sets the rule count to 0
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go1 && (r1_item.kind == KIND_CLEAR)) |=> (r_count == '0))
        else $error("clear did not reset the count");

    // a failed append never reports a packet hit or verdict
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (!o_matched && !o_rule_verdict))
        else $error("hit reported with non-ok status");
`endif

endmodule

`default_nettype wire

[rtl/prc_check.sv]
// Rule validation and stored-entry builder for append items.
`default_nettype none

module prc_check (
    input  var prc_pkg::t_item i_item,
    output logic               o_rule_ok,
    output prc_pkg::t_rule     o_rule
);
    import prc_pkg::*;

    logic w_len_ok;
    logic w_proto_ok;
    logic w_port_ok;
    logic w_act_ok;

    always_comb begin
        w_len_ok   = (i_item.src_prefix_len <= PREFIX_MAX) &&
                     (i_item.dst_prefix_len <= PREFIX_MAX);
        w_proto_ok = (i_item.proto == PROTO_ANY)  || (i_item.proto == PROTO_OTHER) ||
                     (i_item.proto == PROTO_ICMP) || (i_item.proto == PROTO_UDP)   ||
                     (i_item.proto == PROTO_TCP);
        w_port_ok  = (i_item.sport <= 16'(PORT_HIGH)) &&
                     (i_item.dport <= 16'(PORT_HIGH));
        w_act_ok   = (i_item.verdict <= 8'd1);
        o_rule_ok  = w_len_ok && w_proto_ok && w_port_ok && w_act_ok;

        o_rule.direction = i_item.direction;
        o_rule.src_ip    = i_item.src_ip;
        o_rule.src_mask  = len_to_mask(i_item.src_prefix_len);
        o_rule.dst_ip    = i_item.dst_ip;
        o_rule.dst_mask  = len_to_mask(i_item.dst_prefix_len);
        o_rule.proto     = i_item.proto;
        o_rule.sport     = i_item.sport[9:0];
        o_rule.dport     = i_item.dport[9:0];
        o_rule.ack_code  = i_item.ack_code;
        o_rule.action    = i_item.verdict[0];
    end

endmodule

`default_nettype wire

[rtl/prc_rule_mem.sv]
// Rule table memory: one write port, one registered read port.
`default_nettype none

module prc_rule_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire  [AW-1:0]       i_waddr,
    input  var prc_pkg::t_rule  i_wdata,
    input  wire                 i_re,
    input  wire  [AW-1:0]       i_raddr,
    output prc_pkg::t_rule      o_rdata
);
    import prc_pkg::*;

    t_rule r_mem [DEPTH];
    t_rule r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/prc_match.sv]
// Compare of one packet (direction, five-tuple, TCP ACK) against one stored rule.
`default_nettype none

module prc_match (
    input  var prc_pkg::t_pkt  i_pkt,
    input  var prc_pkg::t_rule i_rule,
    output logic               o_hit
);
    import prc_pkg::*;

    function automatic logic port_hit(input logic [15:0] pkt, input logic [9:0] rule);
        logic res;
        if (rule == PORT_WILD) begin
            res = 1'b1;
        end else if (rule == PORT_HIGH) begin
            res = (pkt >= 16'(PORT_HIGH));
        end else begin
            res = (pkt == 16'(rule));
        end
        return res;
    endfunction

    logic w_dir_ok;
    logic w_src_ok;
    logic w_dst_ok;
    logic w_proto_ok;
    logic w_l4;
    logic w_ports_ok;
    logic w_ack_ok;

    always_comb begin
        w_dir_ok   = (i_rule.direction == DIR_ANY) || (i_rule.direction == i_pkt.direction);
        w_src_ok   = ((i_pkt.src_ip ^ i_rule.src_ip) & i_rule.src_mask) == 32'd0;
        w_dst_ok   = ((i_pkt.dst_ip ^ i_rule.dst_ip) & i_rule.dst_mask) == 32'd0;
        // ANY and OTHER rules take every protocol
        w_proto_ok = !((i_rule.proto == PROTO_ICMP) || (i_rule.proto == PROTO_UDP) ||
                       (i_rule.proto == PROTO_TCP)) || (i_rule.proto == i_pkt.proto);
        w_l4       = (i_pkt.proto == PROTO_UDP) || (i_pkt.proto == PROTO_TCP);
        w_ports_ok = !w_l4 || (port_hit(i_pkt.sport, i_rule.sport) &&
                               port_hit(i_pkt.dport, i_rule.dport));
        if (i_pkt.proto != PROTO_TCP) begin
            w_ack_ok = 1'b1;
        end else if (i_rule.ack_code == ACK_YES) begin
            w_ack_ok = (i_pkt.ack_code == 2'd1);
        end else if (i_rule.ack_code == ACK_ANY) begin
            w_ack_ok = 1'b1;
        end else begin
            w_ack_ok = (i_pkt.ack_code == 2'd0);
        end
        o_hit = w_dir_ok && w_src_ok && w_dst_ok && w_proto_ok && w_ports_ok && w_ack_ok;
    end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the packet rule classifier: directed, full, stall, random.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prc_pkg::*;

    localparam int SLOTS = 64;
    // Input register, table read, result register.
    localparam int RESULT_LATENCY = 3;

    // Codes the package leaves out.
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam logic [1:0] DIR_NONE    = 2'd0;
    localparam logic [1:0] DIR_IN      = 2'd1;
    localparam logic [1:0] DIR_OUT     = 2'd2;
    localparam logic [1:0] ACK_NO      = 2'd1;
    localparam logic [1:0] PKT_ACK_OFF = 2'd0;
    localparam logic [1:0] PKT_ACK_ON  = 2'd1;

    // One result item as seen on the output ports.
    typedef struct packed {
        logic [1:0] status;
        logic       matched;
        logic       rule_verdict;
        logic [6:0] count;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic [1:0]  i_direction = '0;
    logic [31:0] i_src_ip = '0;
    logic [5:0]  i_src_prefix_len = '0;
    logic [31:0] i_dst_ip = '0;
    logic [5:0]  i_dst_prefix_len = '0;
    logic [7:0]  i_proto = '0;
    logic [15:0] i_src_port = '0;
    logic [15:0] i_dst_port = '0;
    logic [1:0]  i_ack_code = '0;
    logic [7:0]  i_verdict = '0;
    logic [5:0]  i_rule_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_matched;
    logic        o_rule_verdict;
    logic [6:0]  o_count;

    packet_rule_classifier_unit #(.TABLE_DEPTH(SLOTS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_direction      (i_direction),
        .i_src_ip         (i_src_ip),
        .i_src_prefix_len (i_src_prefix_len),
        .i_dst_ip         (i_dst_ip),
        .i_dst_prefix_len (i_dst_prefix_len),
        .i_proto          (i_proto),
        .i_src_port       (i_src_port),
        .i_dst_port       (i_dst_port),
        .i_ack_code       (i_ack_code),
        .i_verdict        (i_verdict),
        .i_rule_index     (i_rule_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_matched        (o_matched),
        .o_rule_verdict   (o_rule_verdict),
        .o_count          (o_count)
    );

    // Shadow copy of the rule table, updated in acceptance order.
    t_rule       rule_store [SLOTS];
    int          rules_held = 0;
    t_result     due_results [$];
    int          fail_count = 0;

    // Idle controls: per-cycle odds (percent) of a sender gap or receiver stall.
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_off_req = 0;
    int unsigned hold_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow model of the classifier
    // ------------------------------------------------------------------

    function automatic logic [31:0] net_mask(input logic [5:0] len);
        if (len == 6'd0) return 32'h0;
        return 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    function automatic logic proto_known(input logic [7:0] p);
        return p == PROTO_ICMP || p == PROTO_TCP || p == PROTO_UDP ||
               p == PROTO_ANY || p == PROTO_OTHER;
    endfunction

    // Rule port 0 is a wildcard, 1023 covers the whole upper range.
    function automatic logic port_fits(input logic [15:0] pkt, input logic [9:0] rport);
        if (rport == PORT_WILD) return 1'b1;
        if (rport == PORT_HIGH) return pkt >= 16'd1023;
        return pkt == {6'd0, rport};
    endfunction

    // Applies one accepted item to the shadow table and returns its result.
    function automatic t_result classify_item(input t_item it);
        t_result res;
        t_rule   rl;
        logic    hit;
        res = '0;
        case (it.kind)
            KIND_CLEAR: begin
                rules_held = 0;
            end
            KIND_APPEND: begin
                // Full check comes ahead of validation.
                if (rules_held >= SLOTS) begin
                    res.status = ST_FULL;
                end else if (it.src_prefix_len > PREFIX_MAX || it.dst_prefix_len > PREFIX_MAX ||
                             !proto_known(it.proto) || it.sport > 16'd1023 ||
                             it.dport > 16'd1023 || it.verdict > 8'd1) begin
                    res.status = ST_INVALID;
                end else begin
                    rl.direction = it.direction;
                    rl.src_ip    = it.src_ip;
                    rl.src_mask  = net_mask(it.src_prefix_len);
                    rl.dst_ip    = it.dst_ip;
                    rl.dst_mask  = net_mask(it.dst_prefix_len);
                    rl.proto     = it.proto;
                    rl.sport     = it.sport[9:0];
                    rl.dport     = it.dport[9:0];
                    rl.ack_code  = it.ack_code;
                    rl.action    = it.verdict[0];
                    rule_store[rules_held] = rl;
                    rules_held++;
                end
            end
            KIND_MATCH: begin
                if (int'(it.rule_index) < rules_held) begin
                    rl  = rule_store[it.rule_index];
                    hit = 1'b1;
                    if (rl.direction != DIR_ANY && rl.direction != it.direction) hit = 1'b0;
                    if ((it.src_ip & rl.src_mask) != (rl.src_ip & rl.src_mask)) hit = 1'b0;
                    if ((it.dst_ip & rl.dst_mask) != (rl.dst_ip & rl.dst_mask)) hit = 1'b0;
                    if ((rl.proto == PROTO_ICMP || rl.proto == PROTO_TCP ||
                         rl.proto == PROTO_UDP) && rl.proto != it.proto) hit = 1'b0;
                    // Ports and ACK follow the packet's protocol, not the rule's.
                    if (it.proto == PROTO_UDP || it.proto == PROTO_TCP) begin
                        if (!port_fits(it.sport, rl.sport)) hit = 1'b0;
                        if (!port_fits(it.dport, rl.dport)) hit = 1'b0;
                    end
                    if (it.proto == PROTO_TCP) begin
                        if (rl.ack_code == ACK_YES) begin
                            if (it.ack_code != PKT_ACK_ON) hit = 1'b0;
                        end else if (rl.ack_code != ACK_ANY) begin
                            // Rule code 0 behaves like "no".
                            if (it.ack_code != PKT_ACK_OFF) hit = 1'b0;
                        end
                    end
                    res.matched      = hit;
                    res.rule_verdict = rl.action;
                end
            end
            default: ;
        endcase
        res.count = 7'(rules_held);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    // Every field random; callers overwrite what carries meaning.
    function automatic t_item scrambled_item(input logic [1:0] kind);
        t_item it;
        it.kind           = kind;
        it.direction      = 2'($urandom);
        it.src_ip         = $urandom;
        it.src_prefix_len = 6'($urandom);
        it.dst_ip         = $urandom;
        it.dst_prefix_len = 6'($urandom);
        it.proto          = 8'($urandom);
        it.sport          = 16'($urandom);
        it.dport          = 16'($urandom);
        it.ack_code       = 2'($urandom);
        it.verdict        = 8'($urandom);
        it.rule_index     = 6'($urandom);
        return it;
    endfunction

    function automatic t_item rule_item(input logic [1:0] dir, input logic [31:0] sip,
                                        input logic [5:0] slen, input logic [31:0] dip,
                                        input logic [5:0] dlen, input logic [7:0] proto,
                                        input logic [15:0] sport, input logic [15:0] dport,
                                        input logic [1:0] ack, input logic [7:0] act);
        t_item it;
        it = scrambled_item(KIND_APPEND);
        it.direction      = dir;
        it.src_ip         = sip;
        it.src_prefix_len = slen;
        it.dst_ip         = dip;
        it.dst_prefix_len = dlen;
        it.proto          = proto;
        it.sport          = sport;
        it.dport          = dport;
        it.ack_code       = ack;
        it.verdict        = act;
        return it;
    endfunction

    function automatic t_item packet_item(input logic [5:0] idx, input logic [1:0] dir,
                                          input logic [31:0] sip, input logic [31:0] dip,
                                          input logic [7:0] proto, input logic [15:0] sport,
                                          input logic [15:0] dport, input logic [1:0] ack);
        t_item it;
        it = scrambled_item(KIND_MATCH);
        it.rule_index = idx;
        it.direction  = dir;
        it.src_ip     = sip;
        it.dst_ip     = dip;
        it.proto      = proto;
        it.sport      = sport;
        it.dport      = dport;
        it.ack_code   = ack;
        return it;
    endfunction

    function automatic logic [15:0] pick_rule_port();
        case ($urandom_range(0, 3))
            0:       return 16'(PORT_WILD);
            1:       return 16'(PORT_HIGH);
            default: return 16'($urandom_range(1, 1022));
        endcase
    endfunction

    function automatic logic [7:0] rule_proto();
        case ($urandom_range(0, 4))
            0:       return PROTO_ICMP;
            1:       return PROTO_TCP;
            2:       return PROTO_UDP;
            3:       return PROTO_ANY;
            default: return PROTO_OTHER;
        endcase
    endfunction

    // Packet port that a rule port admits.
    function automatic logic [15:0] port_for(input logic [9:0] rport);
        if (rport == PORT_WILD) return 16'($urandom);
        if (rport == PORT_HIGH) return 16'($urandom_range(1023, 65535));
        return {6'd0, rport};
    endfunction

    function automatic t_item random_rule();
        return rule_item(2'($urandom), $urandom, 6'($urandom_range(0, 32)), $urandom,
                         6'($urandom_range(0, 32)), rule_proto(), pick_rule_port(),
                         pick_rule_port(), 2'($urandom), 8'($urandom_range(0, 1)));
    endfunction

    // A legal rule with exactly one field pushed out of range.
    function automatic t_item broken_rule();
        t_item it;
        it = random_rule();
        case ($urandom_range(0, 5))
            0: it.src_prefix_len = 6'($urandom_range(33, 63));
            1: it.dst_prefix_len = 6'($urandom_range(33, 63));
            2: begin
                do it.proto = 8'($urandom); while (proto_known(it.proto));
            end
            3: it.sport = 16'($urandom_range(1024, 65535));
            4: it.dport = 16'($urandom_range(1024, 65535));
            default: it.verdict = 8'($urandom_range(2, 255));
        endcase
        return it;
    endfunction

    // Mostly packets shaped to hit a held rule, some with one field spoiled.
    function automatic t_item probe_packet();
        t_item       it;
        t_rule       rl;
        logic [5:0]  idx;
        logic [7:0]  proto;
        logic [1:0]  ack;
        if (rules_held > 0 && $urandom_range(99) < 85)
            idx = 6'($urandom_range(0, rules_held - 1));
        else
            idx = 6'($urandom_range(0, 63));
        if (int'(idx) >= rules_held) begin
            it = scrambled_item(KIND_MATCH);
            it.rule_index = idx;
            return it;
        end
        rl = rule_store[idx];
        if (rl.proto == PROTO_ICMP || rl.proto == PROTO_TCP || rl.proto == PROTO_UDP)
            proto = rl.proto;
        else
            case ($urandom_range(0, 3))
                0:       proto = PROTO_ICMP;
                1:       proto = PROTO_TCP;
                2:       proto = PROTO_UDP;
                default: proto = 8'($urandom);
            endcase
        if (rl.ack_code == ACK_YES)      ack = PKT_ACK_ON;
        else if (rl.ack_code == ACK_ANY) ack = 2'($urandom);
        else                             ack = PKT_ACK_OFF;
        it = packet_item(idx,
                         rl.direction == DIR_ANY ? 2'($urandom_range(1, 2)) : rl.direction,
                         (rl.src_ip & rl.src_mask) | ($urandom & ~rl.src_mask),
                         (rl.dst_ip & rl.dst_mask) | ($urandom & ~rl.dst_mask),
                         proto, port_for(rl.sport), port_for(rl.dport), ack);
        if ($urandom_range(99) < 35)
            case ($urandom_range(0, 6))
                0:       it.direction ^= 2'($urandom_range(1, 3));
                1:       it.src_ip[$urandom_range(0, 31)] ^= 1'b1;
                2:       it.dst_ip[$urandom_range(0, 31)] ^= 1'b1;
                3:       it.proto = 8'($urandom);
                4:       it.sport = 16'($urandom);
                5:       it.dport = 16'($urandom);
                default: it.ack_code = 2'($urandom);
            endcase
        return it;
    endfunction

    // Random mix: mostly probes against held rules, steady appends, rare clears.
    function automatic t_item traffic_item();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 2 || (rules_held == SLOTS && roll < 25)) return scrambled_item(KIND_CLEAR);
        if (roll < 4)  return scrambled_item(KIND_SPARE);
        if (roll < 24) return random_rule();
        if (roll < 30) return broken_rule();
        return probe_packet();
    endfunction

    // ------------------------------------------------------------------
    // Input side: drive one item, hold it until taken, then maybe idle
    // ------------------------------------------------------------------

    task automatic send_item(input t_item it);
        i_valid          <= 1'b1;
        i_kind           <= it.kind;
        i_direction      <= it.direction;
        i_src_ip         <= it.src_ip;
        i_src_prefix_len <= it.src_prefix_len;
        i_dst_ip         <= it.dst_ip;
        i_dst_prefix_len <= it.dst_prefix_len;
        i_proto          <= it.proto;
        i_src_port       <= it.sport;
        i_dst_port       <= it.dport;
        i_ack_code       <= it.ack_code;
        i_verdict        <= it.verdict;
        i_rule_index     <= it.rule_index;
        do @(posedge i_clk); while (!o_ready);
        // Accepted at this edge; predict now so the next item sees the updated table.
        due_results.push_back(classify_item(it));
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, plus long hold-offs on request
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_off_req != 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Four-state compare so unknown outputs count as mismatches.
    task automatic check_field(input string name, input logic [6:0] want,
                               input logic [6:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Every taken result is compared against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d matched %0d",
                         $time, o_status, o_matched);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 7'(want.status), 7'(o_status));
                check_field("matched", 7'(want.matched), 7'(o_matched));
                check_field("rule_verdict", 7'(want.rule_verdict), 7'(o_rule_verdict));
                check_field("count", want.count, o_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every kind, invalid rules and each match corner.
    task automatic test_directed_cases();
        idle_pct  = 26;
        stall_pct = 26;
        send_item(packet_item(6'd0, DIR_IN, 32'h0, 32'h0, PROTO_ICMP, 16'd0, 16'd0,
                              PKT_ACK_OFF));   // empty table
        send_item(rule_item(DIR_NONE, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_ICMP, 16'd0, 16'd0,
                            2'd0, 8'd0));
        send_item(rule_item(DIR_IN, 32'hC0A8_0000, 6'd16, 32'hFFFF_FFFF, 6'd32, PROTO_TCP,
                            16'd0, 16'd1023, ACK_YES, 8'd1));
        send_item(rule_item(DIR_OUT, 32'h0A00_0001, 6'd32, 32'h8000_0000, 6'd1, PROTO_UDP,
                            16'd1022, 16'd1, ACK_ANY, 8'd1));
        send_item(rule_item(DIR_ANY, 32'hFFFF_FFFF, 6'd8, 32'h0, 6'd31, PROTO_ANY,
                            16'd0, 16'd0, ACK_NO, 8'd0));
        send_item(rule_item(DIR_ANY, 32'h1234_5678, 6'd0, 32'h9ABC_DEF0, 6'd0, PROTO_OTHER,
                            16'd1023, 16'd1023, 2'd0, 8'd1));
        // Each rejected for a single field.
        send_item(rule_item(DIR_IN, 32'h0, 6'd33, 32'h0, 6'd0, PROTO_TCP, 16'd0, 16'd0,
                            ACK_ANY, 8'd0));
        send_item(rule_item(DIR_IN, 32'h0, 6'd0, 32'h0, 6'd63, PROTO_TCP, 16'd0, 16'd0,
                            ACK_ANY, 8'd0));
        send_item(rule_item(DIR_IN, 32'h0, 6'd0, 32'h0, 6'd0, 8'd2, 16'd0, 16'd0,
                            ACK_ANY, 8'd0));
        send_item(rule_item(DIR_IN, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_UDP, 16'd1024, 16'd0,
                            ACK_ANY, 8'd0));
        send_item(rule_item(DIR_IN, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_UDP, 16'd0, 16'hFFFF,
                            ACK_ANY, 8'd0));
        send_item(rule_item(DIR_IN, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_UDP, 16'd0, 16'd0,
                            ACK_ANY, 8'd255));
        // Direction 0 rule only takes direction 0 packets.
        send_item(packet_item(6'd0, DIR_NONE, $urandom, $urandom, PROTO_ICMP, 16'd0, 16'd0,
                              PKT_ACK_OFF));
        send_item(packet_item(6'd0, DIR_IN, $urandom, $urandom, PROTO_ICMP, 16'd0, 16'd0,
                              PKT_ACK_OFF));
        // TCP: high port range, ACK yes, and a packet ACK code above 1.
        send_item(packet_item(6'd1, DIR_IN, 32'hC0A8_1234, 32'hFFFF_FFFF, PROTO_TCP,
                              16'hFFFF, 16'hFFFF, PKT_ACK_ON));
        send_item(packet_item(6'd1, DIR_IN, 32'hC0A8_1234, 32'hFFFF_FFFF, PROTO_TCP,
                              16'hFFFF, 16'hFFFF, 2'd2));
        send_item(packet_item(6'd1, DIR_IN, 32'hC0A8_1234, 32'hFFFF_FFFF, PROTO_TCP,
                              16'hFFFF, 16'd1022, PKT_ACK_ON));
        send_item(packet_item(6'd2, DIR_OUT, 32'h0A00_0001, 32'hFFFF_0000, PROTO_UDP,
                              16'd1022, 16'd1, 2'd3));
        send_item(packet_item(6'd3, DIR_OUT, $urandom, 32'h0000_0001, PROTO_TCP,
                              16'd80, 16'd443, PKT_ACK_OFF));
        send_item(packet_item(6'd3, DIR_OUT, $urandom, 32'h0000_0001, PROTO_TCP,
                              16'd80, 16'd443, 2'd3));
        // Other protocol skips the port checks; TCP against the same rule does not.
        send_item(packet_item(6'd4, DIR_IN, $urandom, $urandom, 8'd200, 16'd5, 16'd5,
                              PKT_ACK_OFF));
        send_item(packet_item(6'd4, DIR_IN, $urandom, $urandom, PROTO_TCP, 16'd1022,
                              16'd2000, PKT_ACK_OFF));
        send_item(packet_item(6'd5, DIR_IN, $urandom, $urandom, PROTO_ICMP, 16'd0, 16'd0,
                              PKT_ACK_OFF));   // index at the count
        send_item(scrambled_item(KIND_SPARE));
        send_item(scrambled_item(KIND_CLEAR));
        drain_results();
    endtask

    // Fill all slots, then appends (good and bad) must report full.
    task automatic test_table_full();
        idle_pct  = 0;
        stall_pct = 26;
        send_item(scrambled_item(KIND_CLEAR));
        repeat (SLOTS) send_item(random_rule());
        repeat (3) send_item(random_rule());
        repeat (3) send_item(broken_rule());
        repeat (12) send_item(probe_packet());
        send_item(packet_item(6'd63, DIR_IN, $urandom, $urandom, PROTO_ICMP, 16'd0, 16'd0,
                              PKT_ACK_OFF));
        send_item(scrambled_item(KIND_CLEAR));
        send_item(packet_item(6'd0, DIR_IN, $urandom, $urandom, PROTO_ICMP, 16'd0, 16'd0,
                              PKT_ACK_OFF));
        drain_results();
    endtask

    // Long receiver hold-off while the sender keeps pushing.
    task automatic test_input_backpressure();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_off_req = 150;
        repeat (40) send_item(traffic_item());
        drain_results();
    endtask

    task automatic test_random_traffic(input int unsigned sender_idle,
                                       input int unsigned receiver_stall, input int n);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (n) send_item(traffic_item());
        drain_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_table_full();
        test_input_backpressure();
        test_random_traffic(0, 0, 380);
        test_random_traffic(72, 0, 380);
        test_random_traffic(0, 72, 380);
        test_random_traffic(26, 26, 380);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
